### sv/http_chunked_body_decoder_top_macros.svh
// Assertion macros for the chunked body decoder checker.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH

// Plain property, sampled on clk and disabled while in reset.
`define HCBD_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A stalled beat stays valid and keeps its payload.
`define HCBD_HOLD(lbl, vld, stl, pay, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && stl) |=> (vld && $stable(pay))) else $error(msg);

`endif

### sv/hcbd_pkg.sv
package hcbd_pkg;

	localparam int SIZE_WIDTH  = 64;
	localparam int COUNT_WIDTH = 32;

	localparam logic [7:0] CHAR_CR  = 8'h0d;
	localparam logic [7:0] CHAR_LF  = 8'h0a;
	localparam logic [7:0] CHAR_SP  = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef enum logic [3:0] {
		PH_LEAD    = 4'd0,
		PH_DIGITS  = 4'd1,
		PH_REST    = 4'd2,
		PH_DATA    = 4'd3,
		PH_DATA_CR = 4'd4,
		PH_DATA_LF = 4'd5,
		PH_TRAILER = 4'd6,
		PH_DONE    = 4'd7,
		PH_ERROR   = 4'd8
	} phase_t;

	typedef struct packed {
		logic       body_start;
		logic [7:0] body_byte;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  payload_byte;
		logic [31:0] decoded_total;
		logic [31:0] consumed_total;
	} out_beat_t;

endpackage

### sv/hcbd_in_reg.sv
module hcbd_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               body_valid,
	output logic               body_stall,
	input  hcbd_pkg::in_beat_t body,
	input  logic               advance,
	output logic               valid_s1,
	output hcbd_pkg::in_beat_t beat_s1
);

	logic accept;

	assign body_stall = valid_s1 && !advance;
	assign accept     = body_valid && !body_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1 <= body;
		end
	end

endmodule

### sv/hcbd_parser.sv
module hcbd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  hcbd_pkg::in_beat_t  beat,
	output logic                push,
	output hcbd_pkg::out_beat_t res
);

	typedef struct packed {
		logic cr;
		logic over;
		logic digit;
	} line_flags_t;

	typedef struct packed {
		hcbd_pkg::phase_t                  phase;
		logic [hcbd_pkg::SIZE_WIDTH-1:0]   acc;
		line_flags_t                       flags;
	} size_st_t;

	typedef struct packed {
		hcbd_pkg::phase_t                  phase;
		logic [hcbd_pkg::SIZE_WIDTH-1:0]   acc;
		logic [hcbd_pkg::SIZE_WIDTH-1:0]   left;
		line_flags_t                       flags;
		logic [hcbd_pkg::COUNT_WIDTH-1:0]  dec;
		logic [hcbd_pkg::COUNT_WIDTH-1:0]  con;
	} state_t;

	localparam state_t ST_RESET = '{
		phase: hcbd_pkg::PH_LEAD,
		acc:   '0,
		left:  '0,
		flags: '0,
		dec:   '0,
		con:   '0
	};

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		if (c >= "0" && c <= "9") begin
			v = 5'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			v = 5'(c - "a" + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			v = 5'(c - "A" + 8'd10);
		end else begin
			v = 5'd16;
		end
		return v;
	endfunction

	function automatic size_st_t size_char(input size_st_t s, input logic [7:0] c);
		size_st_t   r;
		logic [4:0] d;
		r = s;
		d = hex_value(c);
		if (s.phase == hcbd_pkg::PH_LEAD) begin
			if (c != hcbd_pkg::CHAR_SP && c != hcbd_pkg::CHAR_TAB) begin
				if (!d[4]) begin
					r.acc         = hcbd_pkg::SIZE_WIDTH'(d[3:0]);
					r.flags.digit = 1'b1;
					r.phase       = hcbd_pkg::PH_DIGITS;
				end else begin
					r.phase = hcbd_pkg::PH_REST;
				end
			end
		end else if (s.phase == hcbd_pkg::PH_DIGITS) begin
			if (!d[4]) begin
				if (s.acc[hcbd_pkg::SIZE_WIDTH-1 -: 4] != 4'd0) begin
					r.flags.over = 1'b1;
				end
				r.acc = {s.acc[hcbd_pkg::SIZE_WIDTH-5:0], d[3:0]};
			end else begin
				r.phase = hcbd_pkg::PH_REST;
			end
		end
		return r;
	endfunction

	function automatic logic [hcbd_pkg::COUNT_WIDTH-1:0] count_inc(
		input logic [hcbd_pkg::COUNT_WIDTH-1:0] c
	);
		return (&c) ? c : c + 1'b1;
	endfunction

	state_t     st_q;
	state_t     cur;
	state_t     nxt;
	size_st_t   sc;
	logic       emit;
	logic [1:0] kind;
	logic [7:0] b;

	assign b = beat.body_byte;

	always_comb begin
		cur  = beat.body_start ? ST_RESET : st_q;
		nxt  = cur;
		emit = 1'b0;
		kind = hcbd_pkg::KIND_BYTE;
		sc   = '{phase: cur.phase, acc: cur.acc, flags: cur.flags};
		if (cur.phase != hcbd_pkg::PH_DONE && cur.phase != hcbd_pkg::PH_ERROR) begin
			nxt.con = count_inc(cur.con);
			unique case (cur.phase) inside
				hcbd_pkg::PH_LEAD, hcbd_pkg::PH_DIGITS, hcbd_pkg::PH_REST: begin
					if (cur.flags.cr && b == hcbd_pkg::CHAR_LF) begin
						nxt.flags = '0;
						nxt.acc   = '0;
						if (!cur.flags.digit || cur.flags.over) begin
							nxt.phase = hcbd_pkg::PH_ERROR;
							emit      = 1'b1;
							kind      = hcbd_pkg::KIND_ERROR;
						end else if (cur.acc == '0) begin
							nxt.phase = hcbd_pkg::PH_TRAILER;
						end else begin
							nxt.left  = cur.acc;
							nxt.phase = hcbd_pkg::PH_DATA;
						end
					end else begin
						if (cur.flags.cr) begin
							// pending CR was not a line end: plain character
							sc = size_char(sc, hcbd_pkg::CHAR_CR);
							if (b != hcbd_pkg::CHAR_CR) begin
								sc.flags.cr = 1'b0;
								sc          = size_char(sc, b);
							end
						end else if (b == hcbd_pkg::CHAR_CR) begin
							sc.flags.cr = 1'b1;
						end else begin
							sc = size_char(sc, b);
						end
						nxt.phase = sc.phase;
						nxt.acc   = sc.acc;
						nxt.flags = sc.flags;
					end
				end
				hcbd_pkg::PH_DATA: begin
					nxt.dec  = count_inc(cur.dec);
					nxt.left = cur.left - 1'b1;
					if (cur.left == hcbd_pkg::SIZE_WIDTH'(1)) begin
						nxt.phase = hcbd_pkg::PH_DATA_CR;
					end
					emit = 1'b1;
					kind = hcbd_pkg::KIND_BYTE;
				end
				hcbd_pkg::PH_DATA_CR: begin
					if (b != hcbd_pkg::CHAR_CR) begin
						nxt.phase = hcbd_pkg::PH_ERROR;
						emit      = 1'b1;
						kind      = hcbd_pkg::KIND_ERROR;
					end else begin
						nxt.phase = hcbd_pkg::PH_DATA_LF;
					end
				end
				hcbd_pkg::PH_DATA_LF: begin
					if (b != hcbd_pkg::CHAR_LF) begin
						nxt.phase = hcbd_pkg::PH_ERROR;
						emit      = 1'b1;
						kind      = hcbd_pkg::KIND_ERROR;
					end else begin
						nxt.phase = hcbd_pkg::PH_LEAD;
						nxt.flags = '0;
						nxt.acc   = '0;
					end
				end
				hcbd_pkg::PH_TRAILER: begin
					if (cur.flags.cr && b == hcbd_pkg::CHAR_LF) begin
						nxt.flags = '0;
						nxt.phase = hcbd_pkg::PH_DONE;
						emit      = 1'b1;
						kind      = hcbd_pkg::KIND_DONE;
					end else begin
						nxt.flags.cr = (b == hcbd_pkg::CHAR_CR);
					end
				end
				default: begin
					nxt.phase = hcbd_pkg::PH_ERROR;
				end
			endcase
		end
	end

	always_comb begin
		push               = advance && emit;
		res.result_kind    = kind;
		res.payload_byte   = (kind == hcbd_pkg::KIND_BYTE) ? b : 8'd0;
		res.decoded_total  = 32'(nxt.dec);
		res.consumed_total = 32'(nxt.con);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (advance) begin
			st_q <= nxt;
		end
	end

endmodule

### sv/hcbd_out_reg.sv
module hcbd_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  hcbd_pkg::out_beat_t res,
	input  logic                push,
	output logic                ready,
	output logic                result_valid,
	input  logic                result_stall,
	output hcbd_pkg::out_beat_t result
);

	assign ready = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (ready) begin
			result_valid <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && push) begin
			result <= res;
		end
	end

endmodule

### sv/http_chunked_body_decoder_top.sv
// Chunked HTTP body decoder. Takes one raw body byte per beat (body_start
// set on the first byte of each body) and returns at most one result per
// byte: a payload byte, a body-complete mark after the zero chunk and its
// closing line, or an error for a bad size line or a bad chunk end. Bytes
// after done or error give nothing until the next body_start. A byte is
// taken into the input register and parsed from there, and its result is
// held in the result register; with no stall the block sustains one byte
// per clock, set by the update of the parser state register.
module http_chunked_body_decoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                body_valid,
	output logic                body_stall,
	input  hcbd_pkg::in_beat_t  body,
	output logic                result_valid,
	input  logic                result_stall,
	output hcbd_pkg::out_beat_t result
);

	logic                valid_s1;
	hcbd_pkg::in_beat_t  beat_s1;
	logic                advance;
	logic                push;
	logic                ready;
	hcbd_pkg::out_beat_t res;

	assign advance = valid_s1 && ready;

	hcbd_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.body_valid (body_valid),
		.body_stall (body_stall),
		.body       (body),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.beat_s1    (beat_s1)
	);

	hcbd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat    (beat_s1),
		.push    (push),
		.res     (res)
	);

	hcbd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.push         (push),
		.ready        (ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### sv/hcbd_checker.sv
`include "http_chunked_body_decoder_top_macros.svh"

module hcbd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_stall,
	input hcbd_pkg::out_beat_t result
);

	`HCBD_HOLD(a_result_hold, result_valid, result_stall, result, "stalled result beat changed")

	`HCBD_CHECK(a_kind_legal, result_valid |-> (result.result_kind == hcbd_pkg::KIND_BYTE || result.result_kind == hcbd_pkg::KIND_DONE || result.result_kind == hcbd_pkg::KIND_ERROR), "bad result kind")

	`HCBD_CHECK(a_payload_zero, (result_valid && result.result_kind != hcbd_pkg::KIND_BYTE) |-> (result.payload_byte == 8'd0), "payload set on non-byte result")

	`HCBD_CHECK(a_count_order, result_valid |-> (result.decoded_total <= result.consumed_total && result.consumed_total != 32'd0), "decoded count exceeds consumed count")

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
